### src/lkc_pkg.sv
// lkc_pkg: shared types, codes and helpers for the LRU keyed cache.
// No dependencies; imported by every module of the block.
`default_nettype none

package lkc_pkg;

   localparam int FUNC_BITS  = 2;
   localparam int KEY_PORT   = 64;
   localparam int VALUE_PORT = 32;
   localparam int COUNT_PORT = 5;
   localparam int CSR_BITS   = 5;
   localparam int REQ_DATA   = 96;
   localparam int RSP_DATA   = 40;

   typedef enum logic [1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_ERASE  = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LATCH,
      CMD_MATCH,
      CMD_UPDATE,
      CMD_CLR_EMIT
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic     out_free;
      func_type func;
      logic     clr_done;
   } status_type;

   typedef struct packed {
      logic                    hit;
      logic                    vv;
      logic [VALUE_PORT-1:0]   value;
      logic [COUNT_PORT-1:0]   count;
      logic                    last;
   } rsp_type;

   function automatic rsp_type mk_rsp(logic hit, logic vv, logic [VALUE_PORT-1:0] value,
                                      logic [COUNT_PORT-1:0] count, logic last);
      rsp_type r;
      r.hit   = hit;
      r.vv    = vv;
      r.value = vv ? value : '0;
      r.count = count;
      r.last  = last;
      return r;
   endfunction

endpackage

`default_nettype wire

### src/lkc_ctrl.sv
// lkc_ctrl: sequencer for the LRU keyed cache.
// Depends on lkc_pkg; drives lkc_datapath through command and status.
`default_nettype none

module lkc_ctrl
   import lkc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_MATCH;
         end
         ST_MATCH: begin
            state_in = (status.func == FUNC_CLEAR) ? ST_CLEAR : ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            if (status.out_free && status.clr_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd = CMD_LATCH;
         end
         ST_MATCH: cmd = CMD_MATCH;
         ST_UPDATE: begin
            if (status.out_free) cmd = CMD_UPDATE;
         end
         ST_CLEAR: begin
            if (status.out_free) cmd = CMD_CLR_EMIT;
         end
         default: cmd = CMD_NONE;
      endcase
   end

endmodule

`default_nettype wire

### src/lkc_datapath.sv
// lkc_datapath: entry store, recency ranks, tag match and result register.
// Depends on lkc_pkg; sequenced by lkc_ctrl.
`default_nettype none

module lkc_datapath
   import lkc_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [FUNC_BITS-1:0]  req_func,
   input  wire logic [KEY_PORT-1:0]   req_key,
   input  wire logic [VALUE_PORT-1:0] req_value,
   input  wire logic                  csr_wen,
   input  wire logic [CSR_BITS-1:0]   csr_wdata,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp
);

   localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int CAP_RST = (16 > DEPTH) ? DEPTH : 16;

   logic [KEY_BITS-1:0]   key_ff   [DEPTH];
   logic [VALUE_BITS-1:0] val_ff   [DEPTH];
   logic [DEPTH-1:0]      valid_ff;
   logic [IW-1:0]         rank_ff  [DEPTH];
   logic [CW-1:0]         held_ff;
   logic [CW-1:0]         cap_ff;

   func_type              func_ff;
   logic [KEY_BITS-1:0]   rkey_ff;
   logic [VALUE_BITS-1:0] rval_ff;
   logic                  mhit_ff;
   logic [IW-1:0]         mslot_ff, lru_ff, free_ff;
   logic                  has_free_ff;
   logic [IW-1:0]         clr_ff;
   logic                  o_valid_ff;
   rsp_type               o_ff;

   // tag match, least recent, free slot and clear-order slot search
   logic          m_hit, m_free;
   logic [IW-1:0] m_slot, m_lru, m_free_slot, c_slot;
   logic [IW-1:0] top_rank;

   assign top_rank = IW'(held_ff - CW'(1));

   always_comb begin
      m_hit       = 1'b0;
      m_free      = 1'b0;
      m_slot      = '0;
      m_lru       = '0;
      m_free_slot = '0;
      c_slot      = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (valid_ff[i] && key_ff[i] == rkey_ff && !m_hit) begin
            m_hit  = 1'b1;
            m_slot = IW'(i);
         end
         if (valid_ff[i] && rank_ff[i] == top_rank) m_lru = IW'(i);
         if (valid_ff[i] && rank_ff[i] == clr_ff) c_slot = IW'(i);
         if (!valid_ff[i] && !m_free) begin
            m_free      = 1'b1;
            m_free_slot = IW'(i);
         end
      end
   end

   logic          evict;
   logic [IW-1:0] tgt, hit_rank;

   assign evict    = (held_ff >= cap_ff);
   assign tgt      = (evict && (!has_free_ff || lru_ff < free_ff)) ? lru_ff : free_ff;
   assign hit_rank = rank_ff[mslot_ff];

   logic out_free, cap_zero;
   assign out_free = !o_valid_ff || rsp_ready;
   assign cap_zero = (cap_ff == '0);

   assign status.out_free = out_free;
   assign status.func     = func_ff;
   assign status.clr_done = (held_ff == '0) || (clr_ff == top_rank);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         for (int i = 0; i < DEPTH; i++) rank_ff[i] <= '0;
         held_ff    <= '0;
         cap_ff     <= CW'(CAP_RST);
         clr_ff     <= '0;
         o_valid_ff <= 1'b0;
         func_ff    <= FUNC_LOOKUP;
      end else begin
         if (csr_wen) begin
            cap_ff <= (int'(csr_wdata) > DEPTH) ? CW'(DEPTH) : CW'(csr_wdata);
         end
         if (rsp_ready) o_valid_ff <= 1'b0;
         case (cmd)
            CMD_LATCH: begin
               func_ff <= func_type'(req_func);
               rkey_ff <= KEY_BITS'(req_key);
               rval_ff <= VALUE_BITS'(req_value);
               clr_ff  <= '0;
            end
            CMD_MATCH: begin
               mhit_ff     <= m_hit;
               mslot_ff    <= m_slot;
               lru_ff      <= m_lru;
               free_ff     <= m_free_slot;
               has_free_ff <= m_free;
            end
            CMD_UPDATE: begin
               o_valid_ff <= 1'b1;
               case (func_ff)
                  FUNC_LOOKUP: begin
                     if (!cap_zero && mhit_ff) begin
                        for (int i = 0; i < DEPTH; i++)
                           if (valid_ff[i] && rank_ff[i] < hit_rank) rank_ff[i] <= rank_ff[i] + 1'b1;
                        rank_ff[mslot_ff] <= '0;
                        o_ff <= mk_rsp(1'b1, 1'b1, VALUE_PORT'(val_ff[mslot_ff]),
                                       COUNT_PORT'(held_ff), 1'b1);
                     end else begin
                        o_ff <= mk_rsp(1'b0, 1'b0, '0, COUNT_PORT'(held_ff), 1'b1);
                     end
                  end
                  FUNC_INSERT: begin
                     if (cap_zero) begin
                        o_ff <= mk_rsp(1'b0, 1'b1, VALUE_PORT'(rval_ff),
                                       COUNT_PORT'(held_ff), 1'b1);
                     end else if (mhit_ff) begin
                        val_ff[mslot_ff] <= rval_ff;
                        for (int i = 0; i < DEPTH; i++)
                           if (valid_ff[i] && rank_ff[i] < hit_rank) rank_ff[i] <= rank_ff[i] + 1'b1;
                        rank_ff[mslot_ff] <= '0;
                        o_ff <= mk_rsp(1'b0, 1'b0, '0, COUNT_PORT'(held_ff), 1'b1);
                     end else begin
                        // miss: if full, drop the least recent; age all others and place the new key
                        for (int i = 0; i < DEPTH; i++)
                           if (valid_ff[i] && !(evict && IW'(i) == lru_ff))
                              rank_ff[i] <= rank_ff[i] + 1'b1;
                        if (evict) valid_ff[lru_ff] <= 1'b0;
                        valid_ff[tgt] <= 1'b1;
                        key_ff[tgt]   <= rkey_ff;
                        val_ff[tgt]   <= rval_ff;
                        rank_ff[tgt]  <= '0;
                        if (!evict) held_ff <= held_ff + CW'(1);
                        o_ff <= mk_rsp(1'b0, evict, VALUE_PORT'(val_ff[lru_ff]),
                                       COUNT_PORT'(evict ? held_ff : held_ff + CW'(1)), 1'b1);
                     end
                  end
                  FUNC_ERASE: begin
                     if (mhit_ff) begin
                        for (int i = 0; i < DEPTH; i++)
                           if (valid_ff[i] && rank_ff[i] > hit_rank) rank_ff[i] <= rank_ff[i] - 1'b1;
                        valid_ff[mslot_ff] <= 1'b0;
                        rank_ff[mslot_ff]  <= '0;
                        held_ff            <= held_ff - CW'(1);
                        o_ff <= mk_rsp(1'b1, 1'b1, VALUE_PORT'(val_ff[mslot_ff]),
                                       COUNT_PORT'(held_ff - CW'(1)), 1'b1);
                     end else begin
                        o_ff <= mk_rsp(1'b0, 1'b0, '0, COUNT_PORT'(held_ff), 1'b1);
                     end
                  end
                  default: o_ff <= mk_rsp(1'b0, 1'b0, '0, COUNT_PORT'(held_ff), 1'b1);
               endcase
            end
            CMD_CLR_EMIT: begin
               // one item per held entry (one empty item if none), rank order, count reported as zero
               o_valid_ff <= 1'b1;
               clr_ff     <= clr_ff + 1'b1;
               if (held_ff == '0) begin
                  o_ff <= mk_rsp(1'b0, 1'b0, '0, '0, 1'b1);
               end else begin
                  o_ff <= mk_rsp(1'b0, 1'b1, VALUE_PORT'(val_ff[c_slot]), '0,
                                 clr_ff == top_rank);
               end
               if (status.clr_done) begin
                  valid_ff <= '0;
                  for (int i = 0; i < DEPTH; i++) rank_ff[i] <= '0;
                  held_ff  <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp       = o_ff;

endmodule

`default_nettype wire

### src/lru_keyed_cache_unit.sv
// lru_keyed_cache_unit: top level of the fully associative LRU keyed cache.
// Depends on lkc_pkg, lkc_ctrl and lkc_datapath.
//
// Fully associative cache of up to DEPTH entries (key tag, value handle) kept in
// least-recently-used order. req_tuser carries the operation (lookup, insert, erase,
// clear). Lookup, insert and erase take three steps per item: one to latch, one for
// the parallel tag compare and least-recent/free slot search, one to update ranks and
// load the result register. The next item can be taken while that result is still
// waiting for the receiver to accept it; a receiver still holding the previous
// result stalls the update cycle. Clear gives one result per held entry, most recent
// first, at one per cycle while the receiver accepts, set by the rank scan. Capacity written
// through csr_wdata is clamped to DEPTH; writes apply while idle only by the user's care.
`default_nettype none

module lru_keyed_cache_unit
   import lkc_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [REQ_DATA-1:0]  req_tdata,  // key_tag[63:0], value_in[95:64]
   input  wire logic [FUNC_BITS-1:0] req_tuser,  // func[1:0]
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_DATA-1:0]       rsp_tdata,  // value_out[31:0], entry_count[36:32], zero
   output logic [1:0]                rsp_tuser,  // hit[0], value_valid[1]
   output logic                      rsp_tlast,
   input  wire logic                 csr_wen,
   input  wire logic [CSR_BITS-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;
   rsp_type    rsp;

   lkc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lkc_datapath #(
      .DEPTH      (DEPTH),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_func  (req_tuser),
      .req_key   (req_tdata[KEY_PORT-1:0]),
      .req_value (req_tdata[KEY_PORT+VALUE_PORT-1:KEY_PORT]),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {3'b000, rsp.count, rsp.value};
   assign rsp_tuser = {rsp.vv, rsp.hit};
   assign rsp_tlast = rsp.last;

endmodule

`default_nettype wire
